@@ hw/rtl/nfa_pkg.sv @@
package nfa_pkg;

  localparam int NumStatesDef = 64;
  localparam int MaxEdgesDef  = 256;

  localparam int StateW  = 6;
  localparam int SymW    = 8;
  localparam int SlotW   = 8;
  localparam int CountW  = 9;
  localparam int KindW   = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 9;
  localparam int InDataW = 40;
  localparam int OutDataW = 8;

  typedef enum logic [KindW-1:0] {
    KIND_WRITE   = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_STEP    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EDGE_COUNT   = 2'd0,
    CFG_START_STATE  = 2'd1,
    CFG_FINISH_STATE = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_EPS,
    ST_DONE
  } fsm_e;

  // packed as {epsilon, symbol, target, source}
  typedef struct packed {
    logic              eps;
    logic [SymW-1:0]   sym;
    logic [StateW-1:0] tgt;
    logic [StateW-1:0] src;
  } edge_t;

  localparam int EdgeW = $bits(edge_t);

endpackage

@@ hw/rtl/nfa_state_set_stepper.sv @@
// An edge write or an unused kind goes straight to the result without walking the edge table.
// A character step walks the table once for the character move, then makes epsilon passes
// until one adds nothing; a restart makes only the epsilon passes. Each pass reads the first
// N = min(edge_count, MAX_EDGES) edges one at a time through the single edge RAM read port.
// One item is worked at a time; the next is taken while the last result waits.
// Reset: active set empty, edge_count 0, start_state 0, finish_state 1; edge RAM not cleared.
module nfa_state_set_stepper #(
  parameter int NUM_STATES = nfa_pkg::NumStatesDef,
  parameter int MAX_EDGES  = nfa_pkg::MaxEdgesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: edge_slot[7:0], edge_source[13:8], edge_target[19:14],
  //        edge_symbol[27:20], edge_epsilon[28], symbol[36:29], zero fill
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [nfa_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [nfa_pkg::KindW-1:0]      s_axis_tuser,
  // tdata: accepting[0], alive[1], zero fill
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [nfa_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nfa_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [nfa_pkg::CfgW-1:0]       cfg_data_i
);
  import nfa_pkg::*;

  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int UW = (CW > CountW) ? CW : CountW;
  localparam int SW = $clog2(NUM_STATES);
  localparam logic [StateW:0] NsLim = (StateW + 1)'(NUM_STATES);
  localparam logic [UW-1:0]   MaxE  = UW'(MAX_EDGES);

  fsm_e state_q, state_d;
  logic [CountW-1:0] edge_count_q;
  logic [StateW-1:0] start_q, finish_q;
  logic [NUM_STATES-1:0] set_q, set_d, next_q, next_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic rvalid_q, changed_q, changed_d;
  logic [SymW-1:0] symbol_q;
  logic out_valid_q;
  logic [1:0] out_q;

  logic in_acc, out_free, issue, pass_end;
  logic [UW-1:0] count_w;
  logic [CW-1:0] used;
  kind_e kind;
  edge_t wr_edge, rd_edge;
  logic [EdgeW-1:0] rdata;
  logic [AW+SlotW-1:0] slot_wide;
  logic slot_ok, ram_we;
  logic src_hit, tgt_ok;

  assign kind = kind_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign out_free = !out_valid_q || m_axis_tready;

  assign count_w = UW'(edge_count_q);
  assign used = (count_w > MaxE) ? CW'(MaxE) : CW'(count_w);

  assign wr_edge.src = s_axis_tdata[13:8];
  assign wr_edge.tgt = s_axis_tdata[19:14];
  assign wr_edge.sym = s_axis_tdata[27:20];
  assign wr_edge.eps = s_axis_tdata[28];
  assign slot_wide = (AW + SlotW)'(s_axis_tdata[7:0]);
  assign slot_ok = slot_wide < (AW + SlotW)'(MAX_EDGES);
  assign ram_we = in_acc && (kind == KIND_WRITE) && slot_ok;

  assign issue = ((state_q == ST_MOVE) || (state_q == ST_EPS)) && (cnt_q < used);
  assign pass_end = !issue && !rvalid_q;

  nfa_ram #(
    .Width(EdgeW),
    .Depth(MAX_EDGES)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_wide[AW-1:0]),
    .wdata_i(wr_edge),
    .re_i   (issue),
    .raddr_i(cnt_q[AW-1:0]),
    .rdata_o(rdata)
  );

  assign rd_edge = edge_t'(rdata);
  assign src_hit = ({1'b0, rd_edge.src} < NsLim) && set_q[rd_edge.src[SW-1:0]];
  assign tgt_ok = {1'b0, rd_edge.tgt} < NsLim;

  always_comb begin
    state_d = state_q;
    set_d = set_q;
    next_d = next_q;
    cnt_d = cnt_q;
    changed_d = changed_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        changed_d = 1'b0;
        if (in_acc) begin
          case (kind)
            KIND_RESTART: begin
              set_d = '0;
              if ({1'b0, start_q} < NsLim) begin
                set_d[start_q[SW-1:0]] = 1'b1;
              end
              state_d = ST_EPS;
            end
            KIND_STEP: begin
              next_d = '0;
              state_d = ST_MOVE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_MOVE: begin
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (rvalid_q && !rd_edge.eps && (rd_edge.sym == symbol_q) && src_hit && tgt_ok) begin
          next_d[rd_edge.tgt[SW-1:0]] = 1'b1;
        end
        if (pass_end) begin
          set_d = next_q;
          cnt_d = '0;
          changed_d = 1'b0;
          state_d = ST_EPS;
        end
      end
      ST_EPS: begin
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (rvalid_q && rd_edge.eps && src_hit && tgt_ok) begin
          set_d[rd_edge.tgt[SW-1:0]] = 1'b1;
          if (!set_q[rd_edge.tgt[SW-1:0]]) begin
            changed_d = 1'b1;
          end
        end
        if (pass_end) begin
          cnt_d = '0;
          changed_d = 1'b0;
          state_d = changed_q ? ST_EPS : ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      set_q <= '0;
      next_q <= '0;
      cnt_q <= '0;
      rvalid_q <= 1'b0;
      changed_q <= 1'b0;
      out_valid_q <= 1'b0;
      edge_count_q <= '0;
      start_q <= '0;
      finish_q <= StateW'(1);
    end else begin
      state_q <= state_d;
      set_q <= set_d;
      next_q <= next_d;
      cnt_q <= cnt_d;
      rvalid_q <= issue;
      changed_q <= changed_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_EDGE_COUNT:   edge_count_q <= cfg_data_i;
          CFG_START_STATE:  start_q <= cfg_data_i[StateW-1:0];
          CFG_FINISH_STATE: finish_q <= cfg_data_i[StateW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      symbol_q <= s_axis_tdata[36:29];
    end
    if (state_q == ST_DONE && out_free) begin
      out_q[0] <= ({1'b0, finish_q} < NsLim) && set_q[finish_q[SW-1:0]];
      out_q[1] <= |set_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {{(OutDataW - 2){1'b0}}, out_q};

  a_rvalid_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> (state_q == ST_MOVE || state_q == ST_EPS))
    else $error("edge read returned outside a table pass");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE || state_q == ST_EPS) |-> (cnt_q <= used))
    else $error("edge counter ran past the used edges");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished item did not reach the output register");

  a_move_to_eps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE && pass_end) |=> (state_q == ST_EPS && cnt_q == '0))
    else $error("character move did not start epsilon closure");

endmodule

@@ hw/rtl/nfa_ram.sv @@
module nfa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
